@@ rtl/core/ccc_pkg.sv @@
// Shared types, register map and constants for the capacitor charge controller.
package ccc_pkg;

    localparam int SAMPLES_DEF = 8;
    localparam int CODE_W      = 14;
    localparam int ADDR_W      = 5;
    localparam int APB_DATA_W  = 32;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 40;
    localparam int SCALE_ROUND = 1 << 23;
    localparam int EMA_ROUND   = 1 << 15;

    localparam logic [1:0] REQ_ADC     = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_INHIBIT = 2'd2;

    localparam logic [2:0] REG_RESULT_SHIFT      = 3'd0;
    localparam logic [2:0] REG_SUM_GAIN          = 3'd1;
    localparam logic [2:0] REG_CAL_OFFSET        = 3'd2;
    localparam logic [2:0] REG_STOP_THRESHOLD    = 3'd3;
    localparam logic [2:0] REG_RESTART_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_RETRY_INTERVAL    = 3'd5;
    localparam logic [2:0] REG_EMA_ALPHA         = 3'd6;

    localparam logic [15:0] RST_STOP_THRESHOLD = 16'hFFFF;
    localparam logic [15:0] RST_RETRY_INTERVAL = 16'd1000;
    localparam logic [15:0] RST_EMA_ALPHA      = 16'h8000;

    typedef struct packed {
        logic [1:0]         result_shift;
        logic [31:0]        sum_gain;
        logic signed [15:0] cal_offset;
        logic [15:0]        stop_threshold;
        logic [15:0]        restart_threshold;
        logic [15:0]        retry_interval;
        logic [15:0]        ema_alpha;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic mul_lo;
        logic mul_hi;
        logic scale;
        logic ema_mul;
        logic ema_add;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic finish;
        logic ema_first;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/core/ccc_regs.sv @@
// APB configuration register file of the charge controller.
module ccc_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ccc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ccc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output ccc_pkg::t_cfg                     o_cfg
);
    import ccc_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_RESULT_SHIFT:      n_cfg.result_shift      = pwdata[1:0];
                REG_SUM_GAIN:          n_cfg.sum_gain          = pwdata;
                REG_CAL_OFFSET:        n_cfg.cal_offset        = $signed(pwdata[15:0]);
                REG_STOP_THRESHOLD:    n_cfg.stop_threshold    = pwdata[15:0];
                REG_RESTART_THRESHOLD: n_cfg.restart_threshold = pwdata[15:0];
                REG_RETRY_INTERVAL:    n_cfg.retry_interval    = pwdata[15:0];
                REG_EMA_ALPHA:         n_cfg.ema_alpha         = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RESULT_SHIFT:      prdata = {30'b0, r_cfg.result_shift};
            REG_SUM_GAIN:          prdata = r_cfg.sum_gain;
            REG_CAL_OFFSET:        prdata = {16'b0, r_cfg.cal_offset};
            REG_STOP_THRESHOLD:    prdata = {16'b0, r_cfg.stop_threshold};
            REG_RESTART_THRESHOLD: prdata = {16'b0, r_cfg.restart_threshold};
            REG_RETRY_INTERVAL:    prdata = {16'b0, r_cfg.retry_interval};
            REG_EMA_ALPHA:         prdata = {16'b0, r_cfg.ema_alpha};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.result_shift      <= '0;
            r_cfg.sum_gain          <= '0;
            r_cfg.cal_offset        <= '0;
            r_cfg.stop_threshold    <= RST_STOP_THRESHOLD;
            r_cfg.restart_threshold <= '0;
            r_cfg.retry_interval    <= RST_RETRY_INTERVAL;
            r_cfg.ema_alpha         <= RST_EMA_ALPHA;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/core/ccc_ctrl.sv @@
// Sequencer of the charge controller: steps each word through the datapath.
module ccc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ccc_pkg::t_stat i_stat,
    output ccc_pkg::t_cmd  o_cmd
);
    import ccc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_EXEC    = 8'b0000_0010,
        ST_MUL_LO  = 8'b0000_0100,
        ST_MUL_HI  = 8'b0000_1000,
        ST_SCALE   = 8'b0001_0000,
        ST_EMA_MUL = 8'b0010_0000,
        ST_EMA_ADD = 8'b0100_0000,
        ST_PUSH    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.finish ? ST_MUL_LO : ST_PUSH;
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = i_stat.ema_first ? ST_PUSH : ST_EMA_MUL;
            end
            ST_EMA_MUL: begin
                o_cmd.ema_mul = 1'b1;
                n_state       = ST_EMA_ADD;
            end
            ST_EMA_ADD: begin
                o_cmd.ema_add = 1'b1;
                n_state       = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/ccc_dp.sv @@
// Datapath: sample accumulation, shared multiplier, scaling, EMA, hysteresis and output word.
module ccc_dp #(
    parameter int SAMPLES_PER_MEASURE = ccc_pkg::SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ccc_pkg::t_cfg                    i_cfg,
    input  ccc_pkg::t_cmd                    i_cmd,
    output ccc_pkg::t_stat                   o_stat,
    input  logic [ccc_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [1:0]                       i_in_user,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [ccc_pkg::OUT_DATA_W-1:0]   o_out_data
);
    import ccc_pkg::*;

    localparam int IDX_W = $clog2(SAMPLES_PER_MEASURE + 1);
    localparam int TW    = CODE_W + $clog2(SAMPLES_PER_MEASURE);
    localparam int MW    = (TW > 17) ? TW : 17;
    localparam int PW    = MW + 17;
    localparam int AW    = TW + 33;
    localparam int SW    = AW - 23;
    localparam int EW    = PW - 15;

    logic [1:0]             r_req;
    logic [15:0]            r_word;
    logic [31:0]            r_now;
    logic                   r_inh;

    logic [IDX_W-1:0]       r_idx, n_idx;
    logic signed [TW-1:0]   r_total, n_total;
    logic [15:0]            r_last, n_last;
    logic                   r_have, n_have;
    logic [15:0]            r_sm, n_sm;
    logic                   r_sm_valid, n_sm_valid;
    logic                   r_charge, n_charge;
    logic                   r_inh_flag, n_inh_flag;
    logic [31:0]            r_edge_time, n_edge_time;
    logic                   r_edge, n_edge;
    logic                   r_done, n_done;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;

    logic [15:0]            shifted;
    logic signed [CODE_W-1:0] code;
    logic signed [TW-1:0]   code_ext;
    logic signed [TW-1:0]   total_add;
    logic                   finish;
    logic [31:0]            elapsed;
    logic                   due;

    logic signed [MW-1:0]   mul_a;
    logic [15:0]            mul_b;
    logic signed [PW-1:0]   prod_c;
    logic signed [16:0]     ema_diff;

    logic signed [AW-1:0]   prod_ext;
    logic signed [AW-1:0]   acc_full;
    logic signed [SW-2:0]   volt_raw;
    logic signed [SW-1:0]   volt_sum;
    logic [15:0]            volt_clamp;

    logic signed [PW-1:0]   step_sum;
    logic signed [PW-17:0]  step;
    logic signed [EW-1:0]   ema_sum;
    logic [15:0]            ema_clamp;

    assign shifted   = r_word >> i_cfg.result_shift;
    assign code      = $signed(shifted[CODE_W-1:0]);
    assign code_ext  = TW'(code);
    assign total_add = r_total + code_ext;
    assign finish    = (r_req == REQ_ADC) && (r_idx != '0)
                       && (r_idx >= IDX_W'(SAMPLES_PER_MEASURE));
    assign elapsed   = r_now - r_edge_time;
    assign due       = elapsed >= {16'b0, i_cfg.retry_interval};

    assign ema_diff  = $signed({1'b0, r_last}) - $signed({1'b0, r_sm});

    always_comb begin
        mul_a = MW'(r_total);
        mul_b = i_cfg.sum_gain[15:0];
        if (i_cmd.mul_hi) begin
            mul_b = i_cfg.sum_gain[31:16];
        end
        if (i_cmd.ema_mul) begin
            mul_a = MW'(ema_diff);
            mul_b = i_cfg.ema_alpha;
        end
    end

    assign prod_c = mul_a * $signed({1'b0, mul_b});

    assign prod_ext = AW'(r_prod);
    assign acc_full = r_acc + (prod_ext <<< 16);
    assign volt_raw = $signed(acc_full[AW-1:24]);
    assign volt_sum = SW'(volt_raw) + SW'(i_cfg.cal_offset);

    always_comb begin
        if (volt_sum[SW-1]) begin
            volt_clamp = '0;
        end else if (|volt_sum[SW-2:16]) begin
            volt_clamp = 16'hFFFF;
        end else begin
            volt_clamp = volt_sum[15:0];
        end
    end

    assign step_sum = r_prod + PW'(EMA_ROUND);
    assign step     = $signed(step_sum[PW-1:16]);
    assign ema_sum  = EW'(step) + EW'($signed({1'b0, r_sm}));

    always_comb begin
        if (ema_sum[EW-1]) begin
            ema_clamp = '0;
        end else if (|ema_sum[EW-2:16]) begin
            ema_clamp = 16'hFFFF;
        end else begin
            ema_clamp = ema_sum[15:0];
        end
    end

    always_comb begin
        n_idx       = r_idx;
        n_total     = r_total;
        n_last      = r_last;
        n_have      = r_have;
        n_sm        = r_sm;
        n_sm_valid  = r_sm_valid;
        n_charge    = r_charge;
        n_inh_flag  = r_inh_flag;
        n_edge_time = r_edge_time;
        n_edge      = r_edge;
        n_done      = r_done;

        if (i_cmd.load_in) begin
            n_edge = 1'b0;
            n_done = 1'b0;
        end

        if (i_cmd.exec) begin
            unique case (r_req)
                REQ_ADC: begin
                    if (r_idx == '0) begin
                        n_total = '0;
                        n_idx   = IDX_W'(1);
                    end else begin
                        n_total = total_add;
                        n_idx   = finish ? '0 : r_idx + IDX_W'(1);
                    end
                end
                REQ_TICK: begin
                    if (r_have) begin
                        if (r_inh_flag) begin
                            n_charge = 1'b0;
                        end else if (r_last >= i_cfg.stop_threshold) begin
                            n_charge = 1'b0;
                        end else if (r_last <= i_cfg.restart_threshold) begin
                            if (!r_charge || due) begin
                                n_charge    = 1'b1;
                                n_edge_time = r_now;
                                n_edge      = 1'b1;
                            end
                        end
                    end
                end
                REQ_INHIBIT: begin
                    n_inh_flag = r_inh;
                    if (r_inh) begin
                        n_charge = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        if (i_cmd.scale) begin
            n_last = volt_clamp;
            n_have = 1'b1;
            n_done = 1'b1;
            if (!r_sm_valid) begin
                n_sm       = volt_clamp;
                n_sm_valid = 1'b1;
            end
        end

        if (i_cmd.ema_add) begin
            n_sm = ema_clamp;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stat.finish    = finish;
    assign o_stat.ema_first = !r_sm_valid;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_total     <= '0;
            r_last      <= '0;
            r_have      <= 1'b0;
            r_sm        <= '0;
            r_sm_valid  <= 1'b0;
            r_charge    <= 1'b0;
            r_inh_flag  <= 1'b0;
            r_edge_time <= '0;
            r_edge      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_total     <= n_total;
            r_last      <= n_last;
            r_have      <= n_have;
            r_sm        <= n_sm;
            r_sm_valid  <= n_sm_valid;
            r_charge    <= n_charge;
            r_inh_flag  <= n_inh_flag;
            r_edge_time <= n_edge_time;
            r_edge      <= n_edge;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req  <= i_in_user;
            r_word <= i_in_data[15:0];
            r_now  <= i_in_data[47:16];
            r_inh  <= i_in_data[48];
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi || i_cmd.ema_mul) begin
            r_prod <= prod_c;
        end
        if (i_cmd.mul_hi) begin
            r_acc <= prod_ext + AW'(SCALE_ROUND);
        end
        if (i_cmd.push) begin
            r_out_data <= {4'b0, r_have, r_sm, r_last, r_done, r_edge, r_charge};
        end
    end

endmodule

@@ rtl/core/capacitor_charge_hysteresis_control_top.sv @@
// Top level of the capacitor charge controller with hysteresis.
//
// Input words arrive on the s_axis channel: tuser carries the request kind (ADC word,
// control tick, set inhibit), tdata carries the ADC frame, the millisecond time and
// the inhibit flag. Every accepted word yields exactly one result word on m_axis with
// the charge drive level, the trigger edge and measurement flags and both voltages.
// Registers are written through the APB port while the block is idle: that is for the
// user to keep, as the block itself does not enforce it. One word is worked at a time.
// Ticks, inhibit requests and ADC words that do not close a measurement go from the
// execute state straight to the push state, which loads the result register; a word
// that closes one first takes the multiply and scale states and, after the first
// measurement, the EMA states on the shared 16-bit-slice multiplier, which runs the
// gain product in two halves and the EMA weight product once. Input waits for the push.
// The result sits in an output register: a stalled receiver holds it while the next
// word is accepted and processed; that word then waits for the register to drain.
// Synchronous reset returns all but the input, product and result data to defaults.
module capacitor_charge_hysteresis_control_top #(
    parameter int SAMPLES_PER_MEASURE = ccc_pkg::SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] adc_word, [47:16] now_ms, [48] inhibit, [55:49] zero
    input  logic [ccc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] charge_drive, [1] restart_edge, [2] measure_done, [18:3] control_voltage,
    // [34:19] filtered_voltage, [35] voltage_valid, [39:36] zero
    output logic [ccc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ccc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ccc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ccc_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    ccc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ccc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ccc_dp #(
        .SAMPLES_PER_MEASURE (SAMPLES_PER_MEASURE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    a_one_word_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a word is in progress");

    a_done_implies_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[35])
        else $error("measurement done without valid voltage");

    a_edge_implies_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
        else $error("trigger edge with charge drive low");

    a_no_voltage_before_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[35] |->
            (m_axis_tdata[34:3] == 32'd0) && !m_axis_tdata[0])
        else $error("voltage or drive reported before first measurement");

endmodule

@@ bench/capacitor_charge_hysteresis_control_checker.sv @@
// Checker for the capacitor charge controller: tracks register writes, predicts and compares result words.
module capacitor_charge_hysteresis_control_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    // [15:0] adc_word, [47:16] now_ms, [48] inhibit, [55:49] zero
    input  logic [ccc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]                         s_axis_tuser,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] charge_drive, [1] restart_edge, [2] measure_done, [18:3] control_voltage,
    // [34:19] filtered_voltage, [35] voltage_valid, [39:36] zero
    input  logic [ccc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ccc_pkg::ADDR_W-1:0]         paddr,
    input  logic [ccc_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                               pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ccc_pkg::*;

    typedef struct packed {
        logic        drive;
        logic        trigger;
        logic        done;
        logic [15:0] volt;
        logic [15:0] filt;
        logic        valid;
    } t_status;

    t_cfg        cfg;
    logic [3:0]  sample_idx;
    int          code_acc;
    logic [15:0] volt_last;
    logic        have_volt;
    logic [15:0] volt_smooth;
    logic        smooth_ok;
    logic        charging;
    logic        inhibited;
    logic [31:0] edge_stamp;
    int          mismatches = 0;
    t_status     expected_status_q[$];

    function automatic logic [15:0] sat16(longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic t_status apply_request(logic [1:0] kind, logic [15:0] word,
                                              logic [31:0] stamp, logic inh);
        t_status     r;
        logic [15:0] shifted;
        logic [13:0] code;
        longint      scaled;
        longint      diff;
        logic [31:0] elapsed;
        r = '0;
        case (kind)
            REQ_ADC: begin
                if (sample_idx == 0) begin
                    code_acc   = 0;
                    sample_idx = 4'd1;
                end else begin
                    shifted  = word >> cfg.result_shift;
                    code     = shifted[13:0];
                    code_acc = code_acc + $signed({{18{code[13]}}, code});
                    if (sample_idx >= SAMPLES_DEF) begin
                        scaled = (longint'(code_acc) * longint'({32'd0, cfg.sum_gain})
                                  + longint'(SCALE_ROUND)) >>> 24;
                        scaled = scaled + longint'($signed(cfg.cal_offset));
                        volt_last = sat16(scaled);
                        have_volt = 1'b1;
                        if (!smooth_ok) begin
                            volt_smooth = volt_last;
                            smooth_ok   = 1'b1;
                        end else begin
                            diff = longint'({48'd0, volt_last}) - longint'({48'd0, volt_smooth});
                            diff = (diff * longint'({48'd0, cfg.ema_alpha})
                                    + longint'(EMA_ROUND)) >>> 16;
                            volt_smooth = sat16(longint'({48'd0, volt_smooth}) + diff);
                        end
                        r.done     = 1'b1;
                        sample_idx = 4'd0;
                    end else begin
                        sample_idx = sample_idx + 4'd1;
                    end
                end
            end
            REQ_TICK: begin
                if (have_volt) begin
                    if (inhibited) begin
                        charging = 1'b0;
                    end else if (volt_last >= cfg.stop_threshold) begin
                        charging = 1'b0;
                    end else if (volt_last <= cfg.restart_threshold) begin
                        elapsed = stamp - edge_stamp;
                        if (!charging || elapsed >= {16'd0, cfg.retry_interval}) begin
                            charging   = 1'b1;
                            edge_stamp = stamp;
                            r.trigger  = 1'b1;
                        end
                    end
                end
            end
            REQ_INHIBIT: begin
                inhibited = inh;
                if (inh) charging = 1'b0;
            end
            default: ;
        endcase
        r.drive = charging;
        r.volt  = volt_last;
        r.filt  = volt_smooth;
        r.valid = have_volt;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        if (!i_rst_n) begin
            cfg.result_shift      = 2'd0;
            cfg.sum_gain          = 32'd0;
            cfg.cal_offset        = 16'sd0;
            cfg.stop_threshold    = RST_STOP_THRESHOLD;
            cfg.restart_threshold = 16'd0;
            cfg.retry_interval    = RST_RETRY_INTERVAL;
            cfg.ema_alpha         = RST_EMA_ALPHA;
            sample_idx  = 4'd0;
            code_acc    = 0;
            volt_last   = 16'd0;
            have_volt   = 1'b0;
            volt_smooth = 16'd0;
            smooth_ok   = 1'b0;
            charging    = 1'b0;
            inhibited   = 1'b0;
            edge_stamp  = 32'd0;
            expected_status_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_RESULT_SHIFT:      cfg.result_shift      = pwdata[1:0];
                    REG_SUM_GAIN:          cfg.sum_gain          = pwdata;
                    REG_CAL_OFFSET:        cfg.cal_offset        = pwdata[15:0];
                    REG_STOP_THRESHOLD:    cfg.stop_threshold    = pwdata[15:0];
                    REG_RESTART_THRESHOLD: cfg.restart_threshold = pwdata[15:0];
                    REG_RETRY_INTERVAL:    cfg.retry_interval    = pwdata[15:0];
                    REG_EMA_ALPHA:         cfg.ema_alpha         = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_status_q.push_back(apply_request(s_axis_tuser, s_axis_tdata[15:0],
                                                          s_axis_tdata[47:16],
                                                          s_axis_tdata[48]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result word with nothing expected, got %0h",
                                 $realtime, m_axis_tdata);
                    end
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("charge_drive", want.drive, m_axis_tdata[0]);
                    check_field("restart_edge", want.trigger, m_axis_tdata[1]);
                    check_field("measure_done", want.done, m_axis_tdata[2]);
                    check_field("control_voltage", want.volt, m_axis_tdata[18:3]);
                    check_field("filtered_voltage", want.filt, m_axis_tdata[34:19]);
                    check_field("voltage_valid", want.valid, m_axis_tdata[35]);
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = expected_status_q.size();
    end

endmodule

@@ bench/capacitor_charge_hysteresis_control_top_tb.sv @@
// Testbench top for the capacitor charge controller: clock, reset, stimulus, stalls and verdict.
module capacitor_charge_hysteresis_control_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccc_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [143:0] PROBE_WORDS = {16'hA5A5, 16'h2000, 16'h0008, 16'h7FF8,
                                            16'h4000, 16'h8000, 16'h0000, 16'hFFFF,
                                            16'h1234};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    capacitor_charge_hysteresis_control_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    capacitor_charge_hysteresis_control_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("capacitor_charge_hysteresis_control_top regression: fail");
            $finish;
        end
    end

    initial begin : result_sink
        int hold;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            hold = rx_idle ? $urandom_range(0, 16) : 0;
            if (hold != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [15:0] word,
                                input logic [31:0] stamp, input logic inh);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, inh, stamp, word};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // hold the sender until every expected word is back, then let the pipeline settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_config(input logic [1:0] shift, input logic [31:0] gain,
                                input logic [15:0] offset, input logic [15:0] stop,
                                input logic [15:0] restart, input logic [15:0] retry,
                                input logic [15:0] alpha);
        write_reg(REG_RESULT_SHIFT, {30'd0, shift});
        write_reg(REG_SUM_GAIN, gain);
        write_reg(REG_CAL_OFFSET, {16'd0, offset});
        write_reg(REG_STOP_THRESHOLD, {16'd0, stop});
        write_reg(REG_RESTART_THRESHOLD, {16'd0, restart});
        write_reg(REG_RETRY_INTERVAL, {16'd0, retry});
        write_reg(REG_EMA_ALPHA, {16'd0, alpha});
    endtask

    initial begin
        int          phase;
        int          sent;
        int          seq_kind;
        int          level;
        int          n_ticks;
        int          k;
        logic [31:0] raw;
        logic [31:0] clock_ms;
        logic [13:0] code;
        logic [1:0]  shift_now;
        logic [31:0] gain_now;
        logic [15:0] offset_now;
        logic [15:0] stop_now;
        logic [15:0] restart_now;
        logic [15:0] retry_now;
        logic [15:0] alpha_now;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_ADC;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        clock_ms      = 32'd0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle = 1'b0;
        send_request(REQ_TICK, 16'h0000, 32'd0, 1'b0);
        send_request(REQ_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(REQ_INHIBIT, 16'h0000, 32'd0, 1'b1);
        send_request(REQ_INHIBIT, 16'h0000, 32'd0, 1'b0);
        drain();
        write_config(2'd3, 32'h0100_0000, 16'hFFFB, 16'd60000, 16'd30000, 16'd100, 16'hFFFF);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        tx_idle = 1'b1;
        for (k = 0; k < 9; k++) begin
            send_request(REQ_ADC, PROBE_WORDS[k*16 +: 16], 32'd0, 1'b0);
        end
        send_request(REQ_TICK, 16'h0000, 32'd0, 1'b0);
        send_request(REQ_TICK, 16'h0000, 32'd50, 1'b0);
        send_request(REQ_TICK, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        send_request(REQ_TICK, 16'h0000, 32'h0000_0040, 1'b0);
        send_request(REQ_INHIBIT, 16'h0000, 32'd0, 1'b1);
        send_request(REQ_TICK, 16'h0000, 32'h0000_0100, 1'b0);
        send_request(REQ_INHIBIT, 16'h0000, 32'd0, 1'b0);
        send_request(REQ_TICK, 16'h0000, 32'h0000_0200, 1'b0);

        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin
                    shift_now = 2'd0; gain_now = 32'h0100_0000; offset_now = 16'd0;
                    stop_now = 16'd45000; restart_now = 16'd20000; retry_now = 16'd300;
                    alpha_now = 16'h4000;
                end
                1: begin
                    shift_now = 2'd1; gain_now = $urandom_range(32'h0080_0000, 32'h0200_0000);
                    offset_now = 16'h8000; stop_now = 16'hFFFF; restart_now = 16'hFFFF;
                    retry_now = 16'd0; alpha_now = 16'hFFFF;
                end
                2: begin
                    shift_now = 2'd2; gain_now = 32'hFFFF_FFFF; offset_now = 16'h7FFF;
                    stop_now = 16'd0; restart_now = 16'd0; retry_now = 16'hFFFF;
                    alpha_now = 16'd0;
                end
                3: begin
                    shift_now = 2'd3; gain_now = 32'd0; offset_now = 16'($urandom);
                    stop_now = 16'($urandom); restart_now = 16'($urandom);
                    retry_now = 16'($urandom); alpha_now = 16'($urandom);
                end
                default: begin
                    shift_now = 2'($urandom_range(0, 3));
                    gain_now = $urandom_range(32'h0080_0000, 32'h0200_0000);
                    offset_now = 16'($urandom_range(0, 4000)) - 16'd2000;
                    stop_now = 16'($urandom_range(20000, 65535));
                    restart_now = 16'($urandom_range(0, stop_now));
                    retry_now = 16'($urandom_range(0, 3000));
                    alpha_now = 16'($urandom);
                end
            endcase
            write_config(shift_now, gain_now, offset_now, stop_now, restart_now, retry_now,
                         alpha_now);
            tx_idle = (phase != 1);
            rx_idle = (phase != 2);
            sent = 0;
            while (sent < 205) begin
                if ($urandom_range(0, 15) == 0) tx_idle = !tx_idle;
                if ($urandom_range(0, 15) == 0) rx_idle = !rx_idle;
                seq_kind = $urandom_range(0, 9);
                if (seq_kind < 7) begin
                    level = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                        : $urandom_range(0, 8191);
                    for (k = 0; k < 9; k++) begin
                        code = 14'(level + $urandom_range(0, 64) - 32);
                        raw  = $urandom;
                        raw  = (raw & ~(32'h3FFF << shift_now)) | ({18'd0, code} << shift_now);
                        send_request(REQ_ADC, raw[15:0], $urandom, 1'($urandom_range(0, 1)));
                    end
                    n_ticks = $urandom_range(1, 3);
                    for (k = 0; k < n_ticks; k++) begin
                        case ($urandom_range(0, 19))
                            0: clock_ms = $urandom;
                            1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * retry_now);
                            default: clock_ms = clock_ms + $urandom_range(0, 2 * retry_now + 16);
                        endcase
                        send_request(REQ_TICK, 16'($urandom), clock_ms,
                                     1'($urandom_range(0, 1)));
                    end
                    sent += 9 + n_ticks;
                end else if (seq_kind == 7) begin
                    send_request(REQ_INHIBIT, 16'($urandom), $urandom, 1'b1);
                    clock_ms = clock_ms + $urandom_range(0, 2 * retry_now + 16);
                    send_request(REQ_TICK, 16'($urandom), clock_ms, 1'($urandom_range(0, 1)));
                    send_request(REQ_INHIBIT, 16'($urandom), $urandom, 1'b0);
                    sent += 3;
                end else if (seq_kind == 8 && $urandom_range(0, 3) == 0) begin
                    drain();
                end else begin
                    send_request(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
                                 1'($urandom_range(0, 1)));
                    sent += 1;
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("capacitor_charge_hysteresis_control_top regression: pass");
        end else begin
            $display("capacitor_charge_hysteresis_control_top regression: fail");
        end
        $finish;
    end

endmodule
